### design/lsp_pkg.sv
`timescale 1ns / 1ps
// lsp_pkg: shared types and constants for the LIFO stack with peek.
// No dependencies.
package lsp_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int OFF_W     = 6;
  localparam int CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [OFF_W-1:0]            off_t;
  typedef logic [CAP_W-1:0]            cap_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OFFSET    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic take;   // item accepted: update count, memory, read port
    logic load;   // load result register
  } cmd_t;

endpackage

### design/lsp_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the LIFO stack: input, result and config write.
// Depends on lsp_pkg.
interface lsp_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  lsp_pkg::word_t      push_value;
  lsp_pkg::off_t       peek_offset;
  modport source (output valid, operation, push_value, peek_offset, input ready);
  modport sink   (input valid, operation, push_value, peek_offset, output ready);
endinterface

interface lsp_out_if;
  logic                valid;
  logic                ready;
  lsp_pkg::status_t    status;
  lsp_pkg::word_t      peek_data;
  lsp_pkg::cnt_t       fill_count;
  logic                is_empty;
  logic                is_full;
  modport source (output valid, status, peek_data, fill_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, status, peek_data, fill_count, is_empty, is_full,
                  output ready);
endinterface

interface lsp_cfg_if;
  logic                valid;
  logic                ready;
  lsp_pkg::cap_t       data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### design/lsp_ctrl.sv
`timescale 1ns / 1ps
// lsp_ctrl: handshake controller for the LIFO stack.
// Depends on lsp_pkg.
module lsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lsp_pkg::cmd_t cmd
);
  import lsp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.load      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### design/lsp_dp.sv
`timescale 1ns / 1ps
// lsp_dp: entry memory, fill counter, capacity register and result register.
// Depends on lsp_pkg.
module lsp_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  lsp_pkg::cmd_t    cmd,
  input  logic [1:0]       operation,
  input  lsp_pkg::word_t   push_value,
  input  lsp_pkg::off_t    peek_offset,
  input  logic             cfg_we,
  input  lsp_pkg::cap_t    cfg_data,
  output lsp_pkg::status_t status,
  output lsp_pkg::word_t   peek_data,
  output lsp_pkg::cnt_t    fill_count,
  output logic             is_empty,
  output logic             is_full
);
  import lsp_pkg::*;

  word_t   mem [DEPTH];
  word_t   rd_data_r;
  cnt_t    count_r;
  cap_t    cap_r;
  status_t st_r, st_nxt;
  logic    peek_ok_r, peek_ok_nxt;
  cnt_t    count_nxt;
  cnt_t    cap_eff;
  idx_t    rd_idx;
  logic    mem_we;

  status_t status_r;
  word_t   peek_data_r;
  cnt_t    fill_r;
  logic    empty_r, full_r;

  assign cap_eff = (cap_r > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
  assign rd_idx  = IDX_W'(count_r - CNT_W'(1) - CNT_W'(peek_offset));

  always_comb begin
    st_nxt      = ST_OK;
    peek_ok_nxt = 1'b0;
    count_nxt   = count_r;
    mem_we      = 1'b0;
    case (op_t'(operation))
      OP_PUSH: begin
        if (count_r >= cap_eff) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          st_nxt = ST_UNDERFLOW;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (CNT_W'(peek_offset) >= count_r) begin
          st_nxt = ST_OFFSET;
        end else begin
          peek_ok_nxt = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take && mem_we) begin
      mem[count_r[IDX_W-1:0]] <= push_value;
    end
    if (cmd.take) begin
      rd_data_r <= mem[rd_idx];
      st_r      <= st_nxt;
      peek_ok_r <= peek_ok_nxt;
    end
    if (cmd.load) begin
      status_r    <= st_r;
      peek_data_r <= peek_ok_r ? rd_data_r : '0;
      fill_r      <= count_r;
      empty_r     <= (count_r == '0);
      full_r      <= (count_r >= cap_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (cmd.take) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  assign status     = status_r;
  assign peek_data  = peek_data_r;
  assign fill_count = fill_r;
  assign is_empty   = empty_r;
  assign is_full    = full_r;

endmodule

### design/lifo_stack_with_peek_core.sv
`timescale 1ns / 1ps
// Top level of the bounded LIFO stack with peek.
// Depends on lsp_pkg, lsp_if, lsp_ctrl, lsp_dp.
//
//  channel | dir | payload
//  in_if   | in  | operation, push_value, peek_offset
//  out_if  | out | status, peek_data, fill_count, is_empty, is_full
//  cfg_if  | in  | data (capacity_limit), always ready
//
// Each item is accepted in S_IDLE (count update, memory write or read), then
// the result register loads in S_EXEC; the memory's registered read port sets this.
// A new item is accepted while a result waits only if it is taken that cycle.
// Reset clears the fill count and sets capacity to 64; memory is not cleared.
// A stalled result holds until out_if.ready.
module lifo_stack_with_peek_core (
  input  logic clk,
  input  logic rst_n,
  lsp_in_if.sink    in_if,
  lsp_out_if.source out_if,
  lsp_cfg_if.sink   cfg_if
);
  import lsp_pkg::*;

  cmd_t cmd;

  assign cfg_if.ready = 1'b1;

  lsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  lsp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .operation   (in_if.operation),
    .push_value  (in_if.push_value),
    .peek_offset (in_if.peek_offset),
    .cfg_we      (cfg_if.valid),
    .cfg_data    (cfg_if.data),
    .status      (out_if.status),
    .peek_data   (out_if.peek_data),
    .fill_count  (out_if.fill_count),
    .is_empty    (out_if.is_empty),
    .is_full     (out_if.is_full)
  );

endmodule

### design/lsp_checker.sv
`timescale 1ns / 1ps
// lsp_checker: port-level assertions for the LIFO stack, bound to the top.
// Depends on lsp_pkg and lifo_stack_with_peek_core.
module lsp_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input lsp_pkg::status_t status,
  input lsp_pkg::word_t   peek_data,
  input lsp_pkg::cnt_t    fill_count,
  input logic             is_empty,
  input logic             is_full
);
  import lsp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (fill_count == '0)))
    else $error("is_empty disagrees with fill_count");

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OVERFLOW |-> is_full)
    else $error("overflow reported on a stack that is not full");

  a_unf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_UNDERFLOW |-> is_empty)
    else $error("underflow reported on a stack that is not empty");

  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> peek_data == '0)
    else $error("nonzero data on a failed item");

endmodule

bind lifo_stack_with_peek_core lsp_checker u_lsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .status     (out_if.status),
  .peek_data  (out_if.peek_data),
  .fill_count (out_if.fill_count),
  .is_empty   (out_if.is_empty),
  .is_full    (out_if.is_full)
);
